// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk; HSD_ASSERT is disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsd_pkg
// types and constants of the hashed string dictionary
// ----------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam int          CFG_W      = 11;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_FOUND        = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_INSERTED     = 3'd2,
    ST_ENTRIES_FULL = 3'd3,
    ST_SLOTS_FULL   = 3'd4,
    ST_KEY_TOO_LONG = 3'd5,
    ST_CLEARED      = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIVGO,
    S_DIV,
    S_PRD,
    S_PCHK,
    S_ECHK,
    S_KRD,
    S_KCHK,
    S_CRD,
    S_CWR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [15:0]        left_id;
    logic [15:0]        right_ctx;
    logic signed [15:0] cost;
    logic [3:0]         pos;
  } pay_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         key_byte;
    logic               last_byte;
    logic [15:0]        entry_left_id;
    logic [15:0]        entry_right_id;
    logic signed [15:0] entry_cost;
    logic [3:0]         entry_pos;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [8:0]         entry_index;
    logic [15:0]        found_left_id;
    logic [15:0]        found_right_id;
    logic signed [15:0] found_cost;
    logic [3:0]         found_pos;
    logic [31:0]        key_hash;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/hsd_stream_if.sv =====
// ----------------------------------------------------------------------------
// hsd_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none

interface hsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/hashed_string_dictionary_core.sv =====
// ----------------------------------------------------------------------------
// hashed_string_dictionary_core
// string-keyed dictionary: fnv-1a hash, linear probing over a slot memory
// ----------------------------------------------------------------------------
// A key byte that is not the last one is hashed and stored in the key buffer. A
// last byte runs the hash through a one-bit-per-cycle remainder unit, then each
// probe reads slot memory in S_PRD and checks it in S_PCHK, and a lookup that
// finds the slot taken reads its entry in S_ECHK; a lookup whose stored hash and
// length match then steps S_KRD and S_KCHK per key byte compared against the key
// store, and an insert steps S_CRD and S_CWR per key byte copied into it. The
// finish state holds while the previous result beat waits. After reset and on
// every clear beat the slot memory is zeroed one slot a cycle while no beat is
// taken; configuration writes are taken at any time.
`default_nettype none

module hashed_string_dictionary_core #(
  parameter int ENTRIES     = 512,
  parameter int SLOTS       = 1024,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [hsd_pkg::CFG_W-1:0]  cfg_wdata,
  hsd_stream_if.sink                      dict_in,
  hsd_stream_if.source                    dict_out
);

  `include "assert_macros.svh"

  localparam int EW  = $clog2(ENTRIES);
  localparam int EW1 = $clog2(ENTRIES + 1);
  localparam int SIW = $clog2(SLOTS);
  localparam int MW  = $clog2(SLOTS + 1);
  localparam int SCW = (MW > hsd_pkg::CFG_W) ? MW : hsd_pkg::CFG_W;
  localparam int LW  = $clog2(MAX_KEY_LEN + 1);
  localparam int LAW = $clog2(MAX_KEY_LEN);
  localparam int KA  = $clog2(ENTRIES * MAX_KEY_LEN);

  typedef struct packed {
    logic [31:0]   hash;
    logic [LW-1:0] len;
    hsd_pkg::pay_t pay;
  } ent_rec_t;

  hsd_pkg::state_t  state, state_next;
  logic [SCW-1:0]   slot_count;
  logic [MW-1:0]    m_eff;
  logic [SIW-1:0]   idx, idx_next;
  logic [MW-1:0]    probe_n, probe_n_next;
  logic [LAW-1:0]   j, j_next;
  logic [EW-1:0]    cur_e, cur_e_next;
  logic [EW1-1:0]   used, used_next;
  logic [SIW-1:0]   clr, clr_next;
  logic             emit_clr, emit_clr_next;
  hsd_pkg::kind_t   op_kind, op_kind_next;
  hsd_pkg::pay_t    pay_q, pay_q_next;
  hsd_pkg::status_t res_status, res_status_next;
  logic [8:0]       res_idx, res_idx_next;
  hsd_pkg::pay_t    res_pay, res_pay_next;
  hsd_pkg::out_item_t out_q;
  logic             out_valid;
  logic             out_free;
  logic             miss;

  // memories
  logic [EW1-1:0]   slot_mem [SLOTS];
  ent_rec_t         ent_mem [ENTRIES];
  logic [7:0]       kst_mem [ENTRIES * MAX_KEY_LEN];
  logic [EW1-1:0]   slot_q;
  ent_rec_t         ent_q;
  logic [7:0]       kst_q;
  logic             slot_we, ent_we, kst_we;
  logic [SIW-1:0]   slot_waddr;
  logic [EW1-1:0]   slot_wdata;
  logic [EW-1:0]    ent_raddr;
  logic [KA-1:0]    kst_addr;

  // key buffer and remainder unit
  logic             kb_byte_en, kb_restart;
  logic [7:0]       kb_rd_data;
  logic [31:0]      kb_hash;
  logic [LW-1:0]    kb_len;
  logic             kb_ovf;
  logic             mod_start, mod_done;
  logic [MW-1:0]    mod_rem;
  logic             in_acc;
  logic             is_ins;

  assign in_acc = dict_in.valid && dict_in.ready;
  assign dict_in.ready = (state == hsd_pkg::S_IDLE);
  assign out_free = !out_valid || dict_out.ready;
  assign is_ins = (op_kind == hsd_pkg::KIND_INSERT);

  always_comb begin
    if (slot_count == '0) begin
      m_eff = MW'(1);
    end else if (slot_count > SCW'(SLOTS)) begin
      m_eff = MW'(SLOTS);
    end else begin
      m_eff = MW'(slot_count);
    end
  end

  hsd_key_buf #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .LW          (LW),
    .LAW         (LAW)
  ) u_key_buf (
    .clk      (clk),
    .rst      (rst),
    .byte_en  (kb_byte_en),
    .key_byte (dict_in.payload.key_byte),
    .restart  (kb_restart),
    .rd_addr  (j),
    .rd_data  (kb_rd_data),
    .hash     (kb_hash),
    .len      (kb_len),
    .ovf      (kb_ovf)
  );

  hsd_modulo #(
    .MW (MW)
  ) u_modulo (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (kb_hash),
    .divisor  (m_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign kst_addr = KA'(KA'(cur_e) * KA'(MAX_KEY_LEN) + KA'(j));

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    probe_n_next    = probe_n;
    j_next          = j;
    cur_e_next      = cur_e;
    used_next       = used;
    clr_next        = clr;
    emit_clr_next   = emit_clr;
    op_kind_next    = op_kind;
    pay_q_next      = pay_q;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    res_pay_next    = res_pay;
    kb_byte_en      = 1'b0;
    kb_restart      = 1'b0;
    mod_start       = 1'b0;
    slot_we         = 1'b0;
    slot_waddr      = idx;
    slot_wdata      = EW1'(used) + EW1'(1);
    ent_we          = 1'b0;
    kst_we          = 1'b0;
    ent_raddr       = cur_e;
    miss            = 1'b0;

    unique case (state)
      hsd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (dict_in.payload.kind) inside
            hsd_pkg::KIND_CLEAR: begin
              kb_restart    = 1'b1;
              clr_next      = '0;
              emit_clr_next = 1'b1;
              state_next    = hsd_pkg::S_CLEAR;
            end
            hsd_pkg::KIND_INSERT, hsd_pkg::KIND_LOOKUP: begin
              kb_byte_en = 1'b1;
              if (dict_in.payload.last_byte) begin
                op_kind_next = dict_in.payload.kind;
                pay_q_next   = '{left_id:   dict_in.payload.entry_left_id,
                                 right_ctx: dict_in.payload.entry_right_id,
                                 cost:      dict_in.payload.entry_cost,
                                 pos:       dict_in.payload.entry_pos};
                state_next   = hsd_pkg::S_DIVGO;
              end
            end
            default: ;
          endcase
        end
      end
      hsd_pkg::S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr;
        slot_wdata = '0;
        clr_next   = clr + SIW'(1);
        if (clr == SIW'(SLOTS - 1)) begin
          used_next = '0;
          if (emit_clr) begin
            res_status_next = hsd_pkg::ST_CLEARED;
            res_idx_next    = '0;
            res_pay_next    = '0;
            state_next      = hsd_pkg::S_FIN;
          end else begin
            state_next = hsd_pkg::S_IDLE;
          end
        end
      end
      hsd_pkg::S_DIVGO: begin
        res_idx_next = '0;
        res_pay_next = '0;
        if (kb_ovf) begin
          res_status_next = hsd_pkg::ST_KEY_TOO_LONG;
          state_next      = hsd_pkg::S_FIN;
        end else if (is_ins && (used >= EW1'(ENTRIES))) begin
          res_status_next = hsd_pkg::ST_ENTRIES_FULL;
          state_next      = hsd_pkg::S_FIN;
        end else begin
          mod_start  = 1'b1;
          state_next = hsd_pkg::S_DIV;
        end
      end
      hsd_pkg::S_DIV: begin
        if (mod_done) begin
          idx_next     = SIW'(mod_rem);
          probe_n_next = '0;
          state_next   = hsd_pkg::S_PRD;
        end
      end
      hsd_pkg::S_PRD: begin
        state_next = hsd_pkg::S_PCHK;
      end
      hsd_pkg::S_PCHK: begin
        ent_raddr = EW'(slot_q - EW1'(1));
        if (slot_q == '0) begin
          if (is_ins) begin
            slot_we    = 1'b1;
            ent_we     = 1'b1;
            cur_e_next = EW'(used);
            j_next     = '0;
            state_next = hsd_pkg::S_CRD;
          end else begin
            res_status_next = hsd_pkg::ST_NOT_FOUND;
            state_next      = hsd_pkg::S_FIN;
          end
        end else if (is_ins) begin
          miss       = 1'b1;
          state_next = hsd_pkg::S_FIN;
        end else begin
          cur_e_next = EW'(slot_q - EW1'(1));
          state_next = hsd_pkg::S_ECHK;
        end
      end
      hsd_pkg::S_ECHK: begin
        j_next = '0;
        if ((ent_q.hash == kb_hash) && (ent_q.len == kb_len)) begin
          state_next = hsd_pkg::S_KRD;
        end else begin
          miss       = 1'b1;
          state_next = hsd_pkg::S_FIN;
        end
      end
      hsd_pkg::S_KRD: begin
        state_next = hsd_pkg::S_KCHK;
      end
      hsd_pkg::S_KCHK: begin
        if (kb_rd_data != kst_q) begin
          miss       = 1'b1;
          state_next = hsd_pkg::S_FIN;
        end else if (LW'(j) + LW'(1) == kb_len) begin
          res_status_next = hsd_pkg::ST_FOUND;
          res_idx_next    = 9'(cur_e);
          res_pay_next    = ent_q.pay;
          state_next      = hsd_pkg::S_FIN;
        end else begin
          j_next     = j + LAW'(1);
          state_next = hsd_pkg::S_KRD;
        end
      end
      hsd_pkg::S_CRD: begin
        state_next = hsd_pkg::S_CWR;
      end
      hsd_pkg::S_CWR: begin
        kst_we = 1'b1;
        if (LW'(j) + LW'(1) == kb_len) begin
          res_status_next = hsd_pkg::ST_INSERTED;
          res_idx_next    = 9'(cur_e);
          used_next       = used + EW1'(1);
          state_next      = hsd_pkg::S_FIN;
        end else begin
          j_next     = j + LAW'(1);
          state_next = hsd_pkg::S_CRD;
        end
      end
      hsd_pkg::S_FIN: begin
        if (out_free) begin
          kb_restart = 1'b1;
          state_next = hsd_pkg::S_IDLE;
        end
      end
      default: state_next = hsd_pkg::S_IDLE;
    endcase

    // probe miss: step to the next slot or give up after m_eff probes
    if (miss) begin
      if (probe_n + MW'(1) == m_eff) begin
        res_status_next = is_ins ? hsd_pkg::ST_SLOTS_FULL : hsd_pkg::ST_NOT_FOUND;
      end else begin
        probe_n_next = probe_n + MW'(1);
        idx_next     = (MW'(idx) + MW'(1) == m_eff) ? '0 : idx + SIW'(1);
        state_next   = hsd_pkg::S_PRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hsd_pkg::S_CLEAR;
      clr        <= '0;
      emit_clr   <= 1'b0;
      used       <= '0;
      slot_count <= SCW'(SLOTS);
      out_valid  <= 1'b0;
      res_status <= hsd_pkg::ST_FOUND;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      emit_clr   <= emit_clr_next;
      used       <= used_next;
      res_status <= res_status_next;
      if (cfg_we) begin
        slot_count <= SCW'(cfg_wdata);
      end
      if (state == hsd_pkg::S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (dict_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    probe_n <= probe_n_next;
    j       <= j_next;
    cur_e   <= cur_e_next;
    op_kind <= op_kind_next;
    pay_q   <= pay_q_next;
    res_idx <= res_idx_next;
    res_pay <= res_pay_next;
    if (state == hsd_pkg::S_FIN && out_free) begin
      out_q.status         <= res_status;
      out_q.entry_index    <= res_idx;
      out_q.found_left_id  <= res_pay.left_id;
      out_q.found_right_id <= res_pay.right_ctx;
      out_q.found_cost     <= res_pay.cost;
      out_q.found_pos      <= res_pay.pos;
      out_q.key_hash       <= (res_status == hsd_pkg::ST_CLEARED) ? '0 : kb_hash;
    end
  end

  // slot, entry and key store memories
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[EW'(used)] <= '{hash: kb_hash, len: kb_len, pay: pay_q};
    end
    ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (kst_we) begin
      kst_mem[kst_addr] <= kb_rd_data;
    end
    kst_q <= kst_mem[kst_addr];
  end

  assign dict_out.valid   = out_valid;
  assign dict_out.payload = out_q;

  `HSD_ASSERT(a_out_from_fin, $rose(dict_out.valid) |-> $past(state == hsd_pkg::S_FIN), "no fin")
  `HSD_ASSERT(a_used_bound, used <= EW1'(ENTRIES), "entry count past capacity")
  `HSD_ASSERT(a_probe_bound, (state == hsd_pkg::S_PCHK) |-> (probe_n < m_eff), "probe overrun")
  `HSD_ASSERT(a_ent_we_room, ent_we |-> (used < EW1'(ENTRIES)), "entry write with store full")

endmodule

`default_nettype wire

// ===== src/hsd_modulo.sv =====
// ----------------------------------------------------------------------------
// hsd_modulo
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_modulo #(
  parameter int MW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   dividend,
  input  wire logic [MW-1:0] divisor,
  output logic               done,
  output logic [MW-1:0]      rem
);

  logic [31:0]   quo;
  logic [MW-1:0] dvs;
  logic [4:0]    cnt;
  logic          busy;
  logic [MW:0]   trial;

  assign trial = {rem, quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[30:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= MW'(trial - {1'b0, dvs});
      end else begin
        rem <= MW'(trial);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hsd_key_buf.sv =====
// ----------------------------------------------------------------------------
// hsd_key_buf
// running fnv-1a hash, key length and the key byte buffer memory
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_key_buf #(
  parameter int MAX_KEY_LEN = 32,
  parameter int LW          = $clog2(MAX_KEY_LEN + 1),
  parameter int LAW         = $clog2(MAX_KEY_LEN)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_en,
  input  wire logic [7:0]     key_byte,
  input  wire logic           restart,
  input  wire logic [LAW-1:0] rd_addr,
  output logic [7:0]          rd_data,
  output logic [31:0]         hash,
  output logic [LW-1:0]       len,
  output logic                ovf
);

  logic [7:0]  kbuf [MAX_KEY_LEN];
  logic [31:0] mixed;

  assign mixed = hash ^ {24'd0, key_byte};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      hash <= hsd_pkg::FNV_OFFSET;
      len  <= '0;
      ovf  <= 1'b0;
    end else if (byte_en) begin
      hash <= 32'(mixed * hsd_pkg::FNV_PRIME);
      if (len < LW'(MAX_KEY_LEN)) begin
        len <= len + LW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && !restart && (len < LW'(MAX_KEY_LEN))) begin
      kbuf[len[LAW-1:0]] <= key_byte;
    end
    rd_data <= kbuf[rd_addr];
  end

endmodule

`default_nettype wire
